// ----- hdl/icr_pkg.sv -----
package icr_pkg;

    // Number of interrupt lines that exist; bits above this read zero.
    localparam int NUM_LINES = 16;

    // Width of the register words and of the source line vector.
    localparam int WORD_W = 16;

    // Lines that exist, as a bit mask over the register word.
    localparam logic [WORD_W-1:0] LINE_MASK = WORD_W'((33'd1 << NUM_LINES) - 33'd1);

    // Item commands.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register word offsets.
    localparam logic [2:0] ADDR_ENABLE  = 3'd0;
    localparam logic [2:0] ADDR_MASK    = 3'd1;
    localparam logic [2:0] ADDR_SET     = 3'd2;
    localparam logic [2:0] ADDR_CLEAR   = 3'd3;
    localparam logic [2:0] ADDR_PENDING = 3'd4;

    // One input item.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0]        reg_addr;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] source_lines;
    } t_icr_in;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_out;
    } t_icr_out;

    // Handshake state of the input stage as seen by the register file.
    typedef struct packed {
        logic valid;
        logic advance;
    } t_icr_ctl;

endpackage

// ----- hdl/icr_in_stage.sv -----
module icr_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  icr_pkg::t_icr_in i_in_data,
    input  logic             i_advance,
    output icr_pkg::t_icr_ctl o_ctl,
    output icr_pkg::t_icr_in o_item
);
    import icr_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_icr_in r_item;
    logic    load;

    // The stage is stalled only while it holds an item that cannot move on.
    assign o_in_stall = r_valid && !i_advance;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag is control state; the payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_in_data;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;
    assign o_item        = r_item;
endmodule

// ----- hdl/icr_regfile.sv -----
module icr_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  icr_pkg::t_icr_ctl i_ctl,
    input  icr_pkg::t_icr_in  i_item,
    output icr_pkg::t_icr_out o_result
);
    import icr_pkg::*;

    logic [WORD_W-1:0] r_line_enable;
    logic              r_global_mask;
    logic [WORD_W-1:0] r_soft_set;
    logic [WORD_W-1:0] r_pending_bits;

    logic [WORD_W-1:0] n_line_enable;
    logic              n_global_mask;
    logic [WORD_W-1:0] n_soft_set;
    logic [WORD_W-1:0] n_pending_bits;
    logic [WORD_W-1:0] read_data;
    logic              commit;

    // State changes when the held item moves into the result register.
    assign commit = i_ctl.valid && i_ctl.advance;

    // Next state and read data for the item in the input stage.
    always_comb begin
        n_line_enable  = r_line_enable;
        n_global_mask  = r_global_mask;
        n_soft_set     = r_soft_set;
        n_pending_bits = r_pending_bits;
        read_data      = '0;
        case (i_item.cmd)
            CMD_TICK: begin
                n_pending_bits = (r_pending_bits | (i_item.source_lines & r_line_enable))
                                 & LINE_MASK;
            end
            CMD_READ: begin
                case (i_item.reg_addr)
                    ADDR_ENABLE:  read_data = r_line_enable;
                    ADDR_MASK:    read_data = {{(WORD_W-1){1'b0}}, r_global_mask};
                    ADDR_SET:     read_data = r_soft_set;
                    ADDR_PENDING: read_data = r_pending_bits;
                    default:      read_data = '0;
                endcase
            end
            CMD_WRITE: begin
                case (i_item.reg_addr)
                    ADDR_ENABLE: begin
                        n_line_enable = i_item.write_data & LINE_MASK;
                    end
                    ADDR_MASK: begin
                        n_global_mask = i_item.write_data[0];
                    end
                    ADDR_SET: begin
                        // Only bits rising against the previous set value raise pending.
                        n_pending_bits = (r_pending_bits | (i_item.write_data & ~r_soft_set))
                                         & LINE_MASK;
                        n_soft_set     = i_item.write_data & LINE_MASK;
                    end
                    ADDR_CLEAR: begin
                        n_pending_bits = r_pending_bits & ~i_item.write_data & LINE_MASK;
                    end
                    default: begin
                        n_pending_bits = r_pending_bits;
                    end
                endcase
            end
            default: begin
                read_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_enable  <= '0;
            r_global_mask  <= 1'b0;
            r_soft_set     <= '0;
            r_pending_bits <= '0;
        end else if (commit) begin
            r_line_enable  <= n_line_enable;
            r_global_mask  <= n_global_mask;
            r_soft_set     <= n_soft_set;
            r_pending_bits <= n_pending_bits;
        end
    end

    // The interrupt output reflects the state after this item's update.
    assign o_result.read_data = read_data;
    assign o_result.irq_out   = (n_pending_bits != '0) && !n_global_mask;
endmodule

// ----- hdl/interrupt_controller_regs.sv -----
// Sixteen-line interrupt controller with five word registers (enable, mask,
// set, clear, pending). Each input transfer is a tick carrying source lines,
// a register read or a register write, and it produces exactly one result
// transfer with the read data and the interrupt level after the update. An
// item passes an input register and then a result register, from which its
// result is offered at the output and transfers when the output is not
// stalled; one item is taken every cycle while the output is not stalled,
// and a stalled result holds the input stage only once that stage is also
// full.
module interrupt_controller_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  icr_pkg::t_icr_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output icr_pkg::t_icr_out o_out_data
);
    import icr_pkg::*;

    logic     r_out_valid;
    logic     n_out_valid;
    t_icr_out r_out_data;
    logic     advance;
    t_icr_ctl ctl;
    t_icr_in  item;
    t_icr_out result;

    // The result register can take a new item when empty or being drained.
    assign advance = !r_out_valid || !i_out_stall;

    icr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_advance  (advance),
        .o_ctl      (ctl),
        .o_item     (item)
    );

    icr_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (item),
        .o_result (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = ctl.valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ctl.valid) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// ----- hdl/icr_checker.sv -----
module icr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input icr_pkg::t_icr_out o_out_data
);
    import icr_pkg::*;

    // A stalled result holds its value until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The input side stalls only when a full result register is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // An accepted item reaches the result register when the output is not stalled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted item did not reach the output");

    // Without a stalled output the input side never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output flows");
endmodule

bind interrupt_controller_regs icr_checker u_icr_checker (.*);
